// File: rtl/core/rps_pkg.sv
package rps_pkg;

    // Default sizes of the partitioner.
    localparam int RPS_MAX_RADIX_BITS  = 10;
    localparam int RPS_COUNT_WIDTH     = 24;
    localparam int RPS_TUPLES_PER_LINE = 8;

    // Fixed field widths of the command, result and configuration ports.
    localparam int RPS_CMD_W   = 3;
    localparam int RPS_KEY_W   = 32;
    localparam int RPS_PAY_W   = 32;
    localparam int RPS_PIDX_W  = 10;
    localparam int RPS_STAT_W  = 2;
    localparam int RPS_CFGI_W  = 2;
    localparam int RPS_CFGD_W  = 32;

    // Configuration register indexes.
    localparam logic [RPS_CFGI_W-1:0] CFG_RADIX_BITS = 2'd0;
    localparam logic [RPS_CFGI_W-1:0] CFG_SHIFT_BITS = 2'd1;
    localparam logic [RPS_CFGI_W-1:0] CFG_ALIGN_MODE = 2'd2;

    // Configuration reset values.
    localparam logic [3:0] RADIX_BITS_RST = 4'd4;
    localparam logic [4:0] SHIFT_BITS_RST = 5'd0;
    localparam logic       ALIGN_MODE_RST = 1'b0;

    // Command codes.
    typedef enum logic [RPS_CMD_W-1:0] {
        CMD_COUNT    = 3'd0,
        CMD_FINALIZE = 3'd1,
        CMD_SCATTER  = 3'd2,
        CMD_READ     = 3'd3,
        CMD_CLEAR    = 3'd4
    } t_cmd;

    // Result status codes.
    localparam logic [RPS_STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [RPS_STAT_W-1:0] ST_OVF   = 2'd1;
    localparam logic [RPS_STAT_W-1:0] ST_RANGE = 2'd2;

endpackage

// File: rtl/core/radix_partition_scatter.sv
// Count: no result; busy through its read-modify-write step. Scatter and read:
// result strobe registered from that step, next beat taken once back in idle.
// Finalize: one histogram read per partition, result when the last padded size is summed.
// Reset and clear: a sweep over all 2^MAX_RADIX_BITS histogram entries, one per
// cycle, with busy high; configuration writes are taken throughout.
// Results leave on a one-cycle strobe; the receiver cannot stall them.
module radix_partition_scatter
    import rps_pkg::*;
#(
    parameter int MAX_RADIX_BITS  = RPS_MAX_RADIX_BITS,
    parameter int COUNT_WIDTH     = RPS_COUNT_WIDTH,
    parameter int TUPLES_PER_LINE = RPS_TUPLES_PER_LINE
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [RPS_CMD_W-1:0]   i_command,
    input  logic [RPS_KEY_W-1:0]   i_key,
    input  logic [RPS_PAY_W-1:0]   i_payload,
    input  logic [RPS_PIDX_W-1:0]  i_part_index,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [RPS_CFGI_W-1:0]  i_cfg_index,
    input  logic [RPS_CFGD_W-1:0]  i_cfg_data,
    output logic                   o_strobe,
    output logic [COUNT_WIDTH-1:0] o_dest_index,
    output logic [RPS_KEY_W-1:0]   o_out_key,
    output logic [RPS_PAY_W-1:0]   o_out_payload,
    output logic [COUNT_WIDTH-1:0] o_part_count,
    output logic [COUNT_WIDTH-1:0] o_part_start,
    output logic [RPS_STAT_W-1:0]  o_status
);

    localparam int AW    = MAX_RADIX_BITS;
    localparam int NPART = 1 << MAX_RADIX_BITS;
    localparam int CW    = COUNT_WIDTH;
    localparam int TW    = AW + 1;
    localparam logic [CW-1:0] CMAX  = '1;
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [4:0]    MRB_E = 5'(MAX_RADIX_BITS);

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_CLEAR     = 5'b00010,
        S_RMW       = 5'b00100,
        S_FIN_ISSUE = 5'b01000,
        S_FIN_DRAIN = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [3:0] r_radix_bits;
    logic [4:0] r_shift_bits;
    logic       r_align_mode;

    logic          r_flag, n_flag;
    logic [AW-1:0] r_cidx, n_cidx;
    logic [AW-1:0] r_fidx, n_fidx;
    logic [CW-1:0] r_off, n_off;
    logic          r_rd_vld, n_rd_vld;
    logic [TW-1:0] r_rd_tag, n_rd_tag;

    // Latched command of the read-modify-write step.
    t_cmd                  r_cmd, n_cmd;
    logic [AW-1:0]         r_addr, n_addr;
    logic                  r_oor, n_oor;
    logic [RPS_KEY_W-1:0]  r_key, n_key;
    logic [RPS_PAY_W-1:0]  r_pay, n_pay;

    // Result registers.
    logic                  r_strobe, n_strobe;
    logic [CW-1:0]         r_dest, n_dest;
    logic [RPS_KEY_W-1:0]  r_okey, n_okey;
    logic [RPS_PAY_W-1:0]  r_opay, n_opay;
    logic [CW-1:0]         r_pcnt, n_pcnt;
    logic [CW-1:0]         r_pstart, n_pstart;
    logic [RPS_STAT_W-1:0] r_stat, n_stat;

    // Memory ports.
    logic            h_we;
    logic [AW-1:0]   h_waddr, h_raddr;
    logic [CW-1:0]   h_wdata, h_rdata;
    logic            o_we;
    logic [AW-1:0]   o_waddr, o_raddr;
    logic [2*CW-1:0] o_wdata, o_rdata;

    // Padding unit ports.
    logic          pad_valid;
    logic [CW:0]   pad_h;
    logic [TW-1:0] pad_tag;

    // Partition decode from the configuration.
    logic [4:0]            eff_bits;
    logic [31:0]           mask32;
    logic [RPS_KEY_W-1:0]  key_m1;
    logic [RPS_KEY_W-1:0]  key_sh;
    logic [AW-1:0]         part;
    logic [31:0]           pidx32;
    logic                  pidx_oor;
    logic [AW-1:0]         fan_m1;
    logic [CW+1:0]         off_sum;

    always_comb begin
        if (r_radix_bits == 4'd0) begin
            eff_bits = 5'd1;
        end else if ({1'b0, r_radix_bits} > MRB_E) begin
            eff_bits = MRB_E;
        end else begin
            eff_bits = {1'b0, r_radix_bits};
        end
    end

    assign mask32   = 32'((33'd1 << eff_bits) - 33'd1);
    assign key_m1   = i_key - 32'd1;
    assign key_sh   = key_m1 >> r_shift_bits;
    assign part     = key_sh[AW-1:0] & mask32[AW-1:0];
    assign pidx32   = {{(32 - RPS_PIDX_W){1'b0}}, i_part_index};
    assign pidx_oor = (pidx32 & ~mask32) != 32'd0;
    assign fan_m1   = mask32[AW-1:0];
    assign off_sum  = {2'b00, r_off} + {1'b0, pad_h};

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix_bits <= RADIX_BITS_RST;
            r_shift_bits <= SHIFT_BITS_RST;
            r_align_mode <= ALIGN_MODE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RADIX_BITS: r_radix_bits <= i_cfg_data[3:0];
                CFG_SHIFT_BITS: r_shift_bits <= i_cfg_data[4:0];
                CFG_ALIGN_MODE: r_align_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer: command decode, read-modify-write, finalize walk, clear sweep.
    always_comb begin
        n_state  = r_state;
        n_flag   = r_flag;
        n_cidx   = r_cidx;
        n_fidx   = r_fidx;
        n_off    = r_off;
        n_rd_vld = 1'b0;
        n_rd_tag = r_rd_tag;
        n_cmd    = r_cmd;
        n_addr   = r_addr;
        n_oor    = r_oor;
        n_key    = r_key;
        n_pay    = r_pay;
        n_strobe = 1'b0;
        n_dest   = r_dest;
        n_okey   = r_okey;
        n_opay   = r_opay;
        n_pcnt   = r_pcnt;
        n_pstart = r_pstart;
        n_stat   = r_stat;
        h_we     = 1'b0;
        h_waddr  = r_addr;
        h_wdata  = h_rdata;
        h_raddr  = r_fidx;
        o_we     = 1'b0;
        o_waddr  = r_addr;
        o_wdata  = o_rdata;
        o_raddr  = r_addr;

        unique case (r_state)
            S_IDLE: begin
                n_key = i_key;
                n_pay = i_payload;
                n_oor = pidx_oor;
                if (start) begin
                    n_cmd = t_cmd'(i_command);
                    unique case (i_command) inside
                        CMD_COUNT, CMD_SCATTER: begin
                            h_raddr = part;
                            o_raddr = part;
                            n_addr  = part;
                            n_state = S_RMW;
                        end
                        CMD_READ: begin
                            h_raddr = pidx32[AW-1:0];
                            o_raddr = pidx32[AW-1:0];
                            n_addr  = pidx32[AW-1:0];
                            n_state = S_RMW;
                        end
                        CMD_FINALIZE: begin
                            n_fidx  = '0;
                            n_off   = '0;
                            n_state = S_FIN_ISSUE;
                        end
                        CMD_CLEAR: begin
                            n_flag  = 1'b0;
                            n_cidx  = '0;
                            n_state = S_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end

            S_CLEAR: begin
                h_we    = 1'b1;
                h_waddr = r_cidx;
                h_wdata = '0;
                n_cidx  = r_cidx + AW'(1);
                if (r_cidx == AW'(NPART - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_RMW: begin
                n_state = S_IDLE;
                unique case (r_cmd)
                    CMD_COUNT: begin
                        h_we = 1'b1;
                        if (h_rdata == CMAX) begin
                            n_flag  = 1'b1;
                            h_wdata = CMAX;
                        end else begin
                            h_wdata = h_rdata + ONE_C;
                        end
                    end
                    CMD_SCATTER: begin
                        o_we = 1'b1;
                        if (o_rdata[CW-1:0] == CMAX) begin
                            n_flag  = 1'b1;
                            o_wdata = o_rdata;
                        end else begin
                            o_wdata = {o_rdata[2*CW-1:CW], o_rdata[CW-1:0] + ONE_C};
                        end
                        n_strobe = 1'b1;
                        n_dest   = o_rdata[CW-1:0];
                        n_okey   = r_key;
                        n_opay   = r_pay;
                        n_pcnt   = '0;
                        n_pstart = '0;
                        n_stat   = n_flag ? ST_OVF : ST_OK;
                    end
                    default: begin
                        // Read of one partition's count and start.
                        n_strobe = 1'b1;
                        n_dest   = '0;
                        n_okey   = '0;
                        n_opay   = '0;
                        if (r_oor) begin
                            n_pcnt   = '0;
                            n_pstart = '0;
                            n_stat   = ST_RANGE;
                        end else begin
                            n_pcnt   = h_rdata;
                            n_pstart = o_rdata[2*CW-1:CW];
                            n_stat   = r_flag ? ST_OVF : ST_OK;
                        end
                    end
                endcase
            end

            S_FIN_ISSUE: begin
                h_raddr  = r_fidx;
                n_rd_vld = 1'b1;
                n_rd_tag = {(r_fidx == fan_m1), r_fidx};
                n_fidx   = r_fidx + AW'(1);
                if (r_fidx == fan_m1) begin
                    n_state = S_FIN_DRAIN;
                end
            end

            default: ;
        endcase

        // Accumulate the prefix sum as padded sizes leave the padding unit.
        if (pad_valid) begin
            o_we    = 1'b1;
            o_waddr = pad_tag[AW-1:0];
            o_wdata = {r_off, r_off};
            if (off_sum > {2'b00, CMAX}) begin
                n_off  = CMAX;
                n_flag = 1'b1;
            end else begin
                n_off = off_sum[CW-1:0];
            end
            if (pad_tag[AW]) begin
                n_strobe = 1'b1;
                n_dest   = '0;
                n_okey   = '0;
                n_opay   = '0;
                n_pcnt   = n_off;
                n_pstart = '0;
                n_stat   = n_flag ? ST_OVF : ST_OK;
                n_state  = S_IDLE;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_flag   <= 1'b0;
            r_cidx   <= '0;
            r_fidx   <= '0;
            r_off    <= '0;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_flag   <= n_flag;
            r_cidx   <= n_cidx;
            r_fidx   <= n_fidx;
            r_off    <= n_off;
            r_rd_vld <= n_rd_vld;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_tag <= n_rd_tag;
        r_cmd    <= n_cmd;
        r_addr   <= n_addr;
        r_oor    <= n_oor;
        r_key    <= n_key;
        r_pay    <= n_pay;
        r_dest   <= n_dest;
        r_okey   <= n_okey;
        r_opay   <= n_opay;
        r_pcnt   <= n_pcnt;
        r_pstart <= n_pstart;
        r_stat   <= n_stat;
    end

    // Histogram memory.
    rps_ram #(
        .WIDTH (CW),
        .DEPTH (NPART)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    // Start offset and write cursor memory, one word per partition.
    rps_ram #(
        .WIDTH (2 * CW),
        .DEPTH (NPART)
    ) u_offset_ram (
        .i_clk   (i_clk),
        .i_we    (o_we),
        .i_waddr (o_waddr),
        .i_wdata (o_wdata),
        .i_raddr (o_raddr),
        .o_rdata (o_rdata)
    );

    // Rounds each partition size up to whole lines during finalize, in align mode.
    rps_line_pad #(
        .COUNT_WIDTH     (CW),
        .TUPLES_PER_LINE (TUPLES_PER_LINE),
        .TAG_WIDTH       (TW)
    ) u_line_pad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_align (r_align_mode),
        .i_valid (r_rd_vld),
        .i_h     (h_rdata),
        .i_tag   (r_rd_tag),
        .o_valid (pad_valid),
        .o_h     (pad_h),
        .o_tag   (pad_tag)
    );

    assign o_strobe      = r_strobe;
    assign o_dest_index  = r_dest;
    assign o_out_key     = r_okey;
    assign o_out_payload = r_opay;
    assign o_part_count  = r_pcnt;
    assign o_part_start  = r_pstart;
    assign o_status      = r_stat;

endmodule

// File: rtl/core/rps_ram.sv
module rps_ram
    import rps_pkg::*;
#(
    parameter int WIDTH = RPS_COUNT_WIDTH,
    parameter int DEPTH = 1 << RPS_MAX_RADIX_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/rps_line_pad.sv
module rps_line_pad
    import rps_pkg::*;
#(
    parameter int COUNT_WIDTH     = RPS_COUNT_WIDTH,
    parameter int TUPLES_PER_LINE = RPS_TUPLES_PER_LINE,
    parameter int TAG_WIDTH       = RPS_MAX_RADIX_BITS + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_align,
    input  logic                   i_valid,
    input  logic [COUNT_WIDTH-1:0] i_h,
    input  logic [TAG_WIDTH-1:0]   i_tag,
    output logic                   o_valid,
    output logic [COUNT_WIDTH:0]   o_h,
    output logic [TAG_WIDTH-1:0]   o_tag
);

    // Line size fits in LW bits, a remainder below twice the line in RW bits.
    localparam int LW = 7;
    localparam int RW = LW + 1;
    localparam int SH = COUNT_WIDTH + LW;
    localparam int PW = COUNT_WIDTH + SH + 1;
    localparam int QW = COUNT_WIDTH + LW;
    localparam logic [SH:0] ONE_SH = (SH + 1)'(1) << SH;
    localparam logic [SH:0] RECIP  = ONE_SH / (SH + 1)'(TUPLES_PER_LINE);
    localparam logic [RW-1:0] LINE_R = RW'(TUPLES_PER_LINE);
    localparam logic [QW-1:0] LINE_Q = QW'(TUPLES_PER_LINE);

    logic                   r_v1, r_v2, r_v3;
    logic [TAG_WIDTH-1:0]   r_t1, r_t2, r_t3;
    logic [COUNT_WIDTH-1:0] r_h1, r_h2;
    logic [PW-1:0]          r_prod1;
    logic [QW-1:0]          r_qt2;
    logic [COUNT_WIDTH:0]   r_ah3;

    logic [COUNT_WIDTH-1:0] q_est;
    logic [QW-1:0]          diff;
    logic [RW-1:0]          rem_raw;
    logic [RW-1:0]          rem_fix;
    logic [RW-1:0]          pad;
    logic [COUNT_WIDTH:0]   n_ah3;

    // The reciprocal estimate of the quotient is low by at most one.
    assign q_est   = r_prod1[SH +: COUNT_WIDTH];
    assign diff    = {{LW{1'b0}}, r_h2} - r_qt2;
    assign rem_raw = diff[RW-1:0];

    // Correct the remainder once, then pad up to the next line boundary in align mode.
    always_comb begin
        rem_fix = (rem_raw >= LINE_R) ? (rem_raw - LINE_R) : rem_raw;
        pad     = (rem_fix == '0) ? '0 : (LINE_R - rem_fix);
        if (i_align) begin
            n_ah3 = {1'b0, r_h2} + (COUNT_WIDTH + 1)'(pad);
        end else begin
            n_ah3 = {1'b0, r_h2};
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Data path: reciprocal product, quotient times line, padded size.
    always_ff @(posedge i_clk) begin
        r_t1    <= i_tag;
        r_h1    <= i_h;
        r_prod1 <= {{(SH + 1){1'b0}}, i_h} * {{COUNT_WIDTH{1'b0}}, RECIP};
        r_t2    <= r_t1;
        r_h2    <= r_h1;
        r_qt2   <= {{LW{1'b0}}, q_est} * LINE_Q;
        r_t3    <= r_t2;
        r_ah3   <= n_ah3;
    end

    assign o_valid = r_v3;
    assign o_h     = r_ah3;
    assign o_tag   = r_t3;

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import rps_pkg::*;

    localparam int CW            = RPS_COUNT_WIDTH;
    localparam int NPART         = 1 << RPS_MAX_RADIX_BITS;
    localparam int TPL           = RPS_TUPLES_PER_LINE;
    localparam int SETTLE_CYCLES = NPART + 64;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_BEATS  = 600;

    localparam logic [CW-1:0]         COUNT_MAX     = '1;
    localparam logic [RPS_CMD_W-1:0]  CMD_UNUSED_LO = 3'd5;
    localparam logic [RPS_CMD_W-1:0]  CMD_UNUSED_HI = 3'd7;
    localparam logic [RPS_CFGI_W-1:0] CFG_SPARE     = 2'd3;
    localparam logic [3:0]            RADIX_SWEEP [6] = '{4'd0, 4'd1, 4'd10, 4'd13, 4'd2, 4'd7};

    // One command beat as the sender presents it.
    typedef struct packed {
        logic [RPS_CMD_W-1:0]  cmd;
        logic [RPS_KEY_W-1:0]  key;
        logic [RPS_PAY_W-1:0]  payload;
        logic [RPS_PIDX_W-1:0] pidx;
    } t_cmd_beat;

    // One result beat; fields without meaning for a command stay zero.
    typedef struct packed {
        logic [CW-1:0]         dest;
        logic [RPS_KEY_W-1:0]  key;
        logic [RPS_PAY_W-1:0]  payload;
        logic [CW-1:0]         count;
        logic [CW-1:0]         start;
        logic [RPS_STAT_W-1:0] status;
    } t_part_result;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   start         = 1'b0;
    logic                   busy;
    logic [RPS_CMD_W-1:0]   i_command     = '0;
    logic [RPS_KEY_W-1:0]   i_key         = '0;
    logic [RPS_PAY_W-1:0]   i_payload     = '0;
    logic [RPS_PIDX_W-1:0]  i_part_index  = '0;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [RPS_CFGI_W-1:0]  i_cfg_index   = '0;
    logic [RPS_CFGD_W-1:0]  i_cfg_data    = '0;
    logic                   o_strobe;
    logic [CW-1:0]          o_dest_index;
    logic [RPS_KEY_W-1:0]   o_out_key;
    logic [RPS_PAY_W-1:0]   o_out_payload;
    logic [CW-1:0]          o_part_count;
    logic [CW-1:0]          o_part_start;
    logic [RPS_STAT_W-1:0]  o_status;

    radix_partition_scatter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .i_part_index  (i_part_index),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_dest_index  (o_dest_index),
        .o_out_key     (o_out_key),
        .o_out_payload (o_out_payload),
        .o_part_count  (o_part_count),
        .o_part_start  (o_part_start),
        .o_status      (o_status)
    );

    // Predicted state of the partitioner and its layout registers.
    logic [CW-1:0] hist_cnt  [NPART] = '{default: '0};
    logic [CW-1:0] part_base [NPART] = '{default: '0};
    logic [CW-1:0] part_next [NPART] = '{default: '0};
    logic          ovf_sticky = 1'b0;
    logic [3:0]    cfg_radix  = RADIX_BITS_RST;
    logic [4:0]    cfg_shift  = SHIFT_BITS_RST;
    logic          cfg_align  = ALIGN_MODE_RST;

    t_cmd_beat    beat_q [$];
    t_part_result awaited [$];
    t_cmd_beat    next_beat;
    t_part_result seen;
    t_part_result want;
    int           n_queued    = 0;
    int           n_taken     = 0;
    int           n_live      = 0;
    int           n_fail      = 0;
    int           idle_left   = 0;
    int           cycle_count = 0;
    bit           idle_enable = 1'b1;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Fan-out in force: radix bits of zero act as one, large values are clipped.
    function automatic int unsigned fanout();
        int unsigned b;
        b = cfg_radix;
        if (b == 0) b = 1;
        if (b > RPS_MAX_RADIX_BITS) b = RPS_MAX_RADIX_BITS;
        return 1 << b;
    endfunction

    // Key minus one wraps, so key zero lands in the top partition unless the shift drops too many ones.
    function automatic int unsigned partition_of(logic [RPS_KEY_W-1:0] key);
        logic [RPS_KEY_W-1:0] k;
        k = (key - 1) >> cfg_shift;
        return k & (fanout() - 1);
    endfunction

    function automatic logic [RPS_STAT_W-1:0] sticky_status();
        return ovf_sticky ? ST_OVF : ST_OK;
    endfunction

    // Apply one accepted beat to the predicted state and queue its result.
    // Saturation of counts, offsets and cursors takes 2^24 beats, far beyond
    // this run, but it is modeled all the same.
    function automatic void advance_partitioner(t_cmd_beat b);
        t_part_result    r;
        longint unsigned total;
        longint unsigned span;
        int unsigned     p;
        int unsigned     fan;
        int unsigned     i;
        r   = '0;
        fan = fanout();
        case (b.cmd)
            CMD_COUNT: begin
                p = partition_of(b.key);
                if (hist_cnt[p] == COUNT_MAX) ovf_sticky = 1'b1;
                else hist_cnt[p] = hist_cnt[p] + 1'b1;
            end
            CMD_FINALIZE: begin
                total = 0;
                for (i = 0; i < fan; i++) begin
                    part_base[i] = CW'(total);
                    part_next[i] = CW'(total);
                    span = hist_cnt[i];
                    if (cfg_align) span = (span + TPL - 1) / TPL * TPL;
                    total += span;
                    if (total > COUNT_MAX) begin
                        total      = COUNT_MAX;
                        ovf_sticky = 1'b1;
                    end
                end
                r.count  = CW'(total);
                r.status = sticky_status();
                awaited.push_back(r);
            end
            CMD_SCATTER: begin
                p      = partition_of(b.key);
                r.dest = part_next[p];
                if (part_next[p] == COUNT_MAX) ovf_sticky = 1'b1;
                else part_next[p] = part_next[p] + 1'b1;
                r.key     = b.key;
                r.payload = b.payload;
                r.status  = sticky_status();
                awaited.push_back(r);
            end
            CMD_READ: begin
                if (b.pidx >= fan) begin
                    r.status = ST_RANGE;
                end else begin
                    r.count  = hist_cnt[b.pidx];
                    r.start  = part_base[b.pidx];
                    r.status = sticky_status();
                end
                awaited.push_back(r);
            end
            CMD_CLEAR: begin
                hist_cnt   = '{default: '0};
                ovf_sticky = 1'b0;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            n_fail++;
        end
    endfunction

    // Driver: presents queued beats, holds each while busy, idles in bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_left <= 0;
        end else begin
            if (start && !busy) begin
                advance_partitioner('{i_command, i_key, i_payload, i_part_index});
                n_taken++;
            end
            if (!(start && busy)) begin
                if (idle_left != 0) begin
                    start     <= 1'b0;
                    idle_left <= idle_left - 1;
                end else if (beat_q.size() != 0) begin
                    next_beat    = beat_q.pop_front();
                    start        <= 1'b1;
                    i_command    <= next_beat.cmd;
                    i_key        <= next_beat.key;
                    i_payload    <= next_beat.payload;
                    i_part_index <= next_beat.pidx;
                    if (idle_enable && $urandom_range(0, 7) == 0)
                        idle_left <= $urandom_range(1, 17);
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed beat must match the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            seen = '{o_dest_index, o_out_key, o_out_payload, o_part_count,
                     o_part_start, o_status};
            if (awaited.size() == 0) begin
                $error("result beat with no prediction waiting");
                n_fail++;
            end else begin
                want = awaited.pop_front();
                check_field("dest_index", want.dest, seen.dest);
                check_field("out_key", want.key, seen.key);
                check_field("out_payload", want.payload, seen.payload);
                check_field("part_count", want.count, seen.count);
                check_field("part_start", want.start, seen.start);
                check_field("status", want.status, seen.status);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** radix_partition_scatter: FAILED **");
            $finish;
        end
    end

    function automatic void queue_beat(logic [RPS_CMD_W-1:0] cmd, logic [RPS_KEY_W-1:0] key,
                                       logic [RPS_PAY_W-1:0] payload,
                                       logic [RPS_PIDX_W-1:0] pidx);
        beat_q.push_back('{cmd, key, payload, pidx});
        n_queued++;
        if (cmd <= CMD_CLEAR) n_live++;
    endfunction

    // Read of a partition, half in range of the current fan-out, half anywhere.
    function automatic void queue_read();
        if ($urandom_range(0, 1) == 0)
            queue_beat(CMD_READ, $urandom, $urandom, RPS_PIDX_W'($urandom));
        else
            queue_beat(CMD_READ, $urandom, $urandom,
                       RPS_PIDX_W'($urandom_range(0, fanout() - 1)));
    endfunction

    // A stray beat that breaks the count-finalize-scatter order.
    function automatic void queue_noise();
        case ($urandom_range(0, 3))
            0: queue_beat(RPS_CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                          $urandom, $urandom, RPS_PIDX_W'($urandom));
            1: queue_read();
            2: queue_beat(CMD_COUNT, $urandom, $urandom, RPS_PIDX_W'($urandom));
            default: queue_beat(CMD_SCATTER, $urandom, $urandom, RPS_PIDX_W'($urandom));
        endcase
    endfunction

    // One relation: clear (mostly), count its keys, finalize (mostly), then
    // scatter them shuffled. Keys repeat often so partitions fill several deep.
    function automatic void queue_relation();
        logic [RPS_KEY_W-1:0] keys [$];
        logic [RPS_KEY_W-1:0] k;
        int                   n;
        int                   i;
        int                   j;
        n = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0)
            queue_beat(CMD_CLEAR, $urandom, $urandom, RPS_PIDX_W'($urandom));
        for (i = 0; i < n; i++) begin
            if (keys.size() != 0 && $urandom_range(0, 1) == 0)
                k = keys[$urandom_range(0, keys.size() - 1)];
            else
                k = $urandom;
            keys.push_back(k);
            queue_beat(CMD_COUNT, k, $urandom, RPS_PIDX_W'($urandom));
            if ($urandom_range(0, 7) == 0) queue_noise();
        end
        if ($urandom_range(0, 9) != 0)
            queue_beat(CMD_FINALIZE, $urandom, $urandom, RPS_PIDX_W'($urandom));
        for (i = keys.size() - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            k       = keys[i];
            keys[i] = keys[j];
            keys[j] = k;
        end
        for (i = 0; i < keys.size(); i++) begin
            queue_beat(CMD_SCATTER, keys[i], $urandom, RPS_PIDX_W'($urandom));
            if ($urandom_range(0, 5) == 0) queue_read();
            if ($urandom_range(0, 11) == 0) queue_noise();
        end
        queue_read();
    endfunction

    task automatic write_reg(logic [RPS_CFGI_W-1:0] idx, logic [RPS_CFGD_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_RADIX_BITS: cfg_radix = val[3:0];
            CFG_SHIFT_BITS: cfg_shift = val[4:0];
            CFG_ALIGN_MODE: cfg_align = val[0];
            default: begin
            end
        endcase
    endtask

    // Unused upper data bits carry random values; only the low bits matter.
    task automatic set_layout(logic [3:0] radix, logic [4:0] shift, logic align);
        write_reg(CFG_RADIX_BITS, ($urandom & ~32'hF) | radix);
        write_reg(CFG_SHIFT_BITS, ($urandom & ~32'h1F) | shift);
        write_reg(CFG_ALIGN_MODE, ($urandom & ~32'h1) | align);
    endtask

    // Let every queued beat go out and every result come back, then give a
    // finalize walk or a clear sweep time to finish.
    task automatic wait_idle();
        while (n_taken != n_queued || awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int         n_dir;
        int         phase;
        logic [3:0] radix;
        logic [4:0] shift;
        logic       align;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(CFG_SPARE, $urandom);

        // Reset layout: key zero and all-ones wrap into the top partitions,
        // reads past the fan-out, unused commands, stable scatter order, clear.
        queue_beat(CMD_COUNT, 32'h0, 32'h0, '0);
        queue_beat(CMD_COUNT, 32'h1, 32'hFFFF_FFFF, '1);
        queue_beat(CMD_COUNT, 32'hFFFF_FFFF, $urandom, '0);
        queue_beat(CMD_COUNT, 32'h10, $urandom, '1);
        queue_beat(CMD_READ, $urandom, $urandom, 10'd16);
        queue_beat(CMD_READ, $urandom, $urandom, '1);
        queue_beat(CMD_UNUSED_LO, $urandom, $urandom, RPS_PIDX_W'($urandom));
        queue_beat(CMD_UNUSED_LO + 3'd1, $urandom, $urandom, RPS_PIDX_W'($urandom));
        queue_beat(CMD_UNUSED_HI, $urandom, $urandom, RPS_PIDX_W'($urandom));
        queue_beat(CMD_FINALIZE, $urandom, $urandom, RPS_PIDX_W'($urandom));
        queue_beat(CMD_READ, $urandom, $urandom, 10'd15);
        queue_beat(CMD_READ, $urandom, $urandom, '0);
        queue_beat(CMD_SCATTER, 32'h10, 32'hFFFF_FFFF, '0);
        queue_beat(CMD_SCATTER, 32'h0, 32'h0, '1);
        queue_beat(CMD_SCATTER, 32'hFFFF_FFFF, $urandom, '0);
        queue_beat(CMD_SCATTER, 32'h1, $urandom, '1);
        queue_beat(CMD_CLEAR, $urandom, $urandom, RPS_PIDX_W'($urandom));
        queue_beat(CMD_READ, $urandom, $urandom, 10'd15);
        wait_idle();

        // Clipped radix, top shift, line padding; this finalize writes every
        // start and cursor entry, so later reads never touch unwritten ones.
        set_layout(4'd15, 5'd31, 1'b1);
        queue_beat(CMD_COUNT, 32'h0, $urandom, '0);
        queue_beat(CMD_COUNT, 32'h8000_0001, $urandom, '1);
        queue_beat(CMD_COUNT, 32'h1, $urandom, '0);
        queue_beat(CMD_FINALIZE, $urandom, $urandom, RPS_PIDX_W'($urandom));
        queue_beat(CMD_READ, $urandom, $urandom, '1);
        queue_beat(CMD_READ, $urandom, $urandom, 10'd1);
        queue_beat(CMD_SCATTER, 32'h8000_0001, $urandom, '0);
        queue_beat(CMD_SCATTER, 32'h0, $urandom, '1);
        queue_beat(CMD_SCATTER, 32'h1, $urandom, '0);
        wait_idle();

        // Random phases, each under a new layout, with a full drain between.
        n_dir = n_live;
        phase = 0;
        while (n_live < n_dir + RANDOM_BEATS) begin
            if (n_live >= n_dir + RANDOM_BEATS * 5 / 6) idle_enable = 1'b0;
            radix = (phase < 6) ? RADIX_SWEEP[phase] : 4'($urandom);
            case (phase % 3)
                0: shift = 5'd31;
                1: shift = 5'd0;
                default: shift = 5'($urandom);
            endcase
            align = (phase < 2) ? phase[0] : 1'($urandom);
            set_layout(radix, shift, align);
            repeat ($urandom_range(1, 2)) queue_relation();
            wait_idle();
            phase++;
        end

        if (n_fail == 0) begin
            $display("** radix_partition_scatter: PASSED **");
        end else begin
            $display("** radix_partition_scatter: FAILED **");
        end
        $finish;
    end

endmodule
